/* hw/rtl/pcbg_pkg.sv */
package pcbg_pkg;

  localparam int DW = 19;   // log2 distance, Q.16
  localparam int VW = 31;   // power value, Q.30
  localparam int LanesN = 3;
  localparam int PipeN = 13;  // lane register stages before the output register

  typedef logic [DW-1:0] d_tab_t [256];
  typedef logic [VW-1:0] v_tab_t [256];
  typedef logic [VW-1:0] r_tab_t [17];

  typedef enum logic [1:0] {
    REG_CONTRAST   = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_GAMMA      = 2'd2
  } reg_idx_e;

  function automatic longint unsigned log2_q16(input int p);
    longint unsigned m;
    longint unsigned frac;
    int e;
    e = 0;
    frac = 0;
    if (p == 0) return 0;
    while ((p >> (e + 1)) != 0) e++;
    m = longint'(p) << (23 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 23;
      frac = frac << 1;
      if (m >= (64'd1 << 24)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned a_in);
    longint unsigned a;
    longint unsigned r;
    longint unsigned b;
    a = a_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic d_tab_t mk_d();
    d_tab_t t;
    for (int p = 0; p < 256; p++) begin
      t[p] = (p == 0) ? '0 : DW'(log2_q16(255) - log2_q16(p));
    end
    return t;
  endfunction

  function automatic r_tab_t mk_r();
    r_tab_t t;
    longint unsigned r;
    r = 64'd1 << 29;
    t[0] = VW'(r);
    for (int k = 1; k <= 16; k++) begin
      r = isqrt(r << 30);
      t[k] = VW'(r);
    end
    return t;
  endfunction

  localparam d_tab_t DTab = mk_d();
  localparam r_tab_t RTab = mk_r();

  // product of factors 1..8 for the upper fraction byte, truncated per step
  function automatic v_tab_t mk_v();
    v_tab_t t;
    longint unsigned v;
    for (int h = 0; h < 256; h++) begin
      v = 64'd1 << 30;
      for (int k = 1; k <= 8; k++) begin
        if (((h >> (8 - k)) & 1) != 0) v = (v * longint'(RTab[k])) >> 30;
      end
      t[h] = VW'(v);
    end
    return t;
  endfunction

  localparam v_tab_t VTab = mk_v();

endpackage

/* hw/rtl/pixel_contrast_brightness_gamma_core.sv */
// Input beats pass through 13 lane register stages and then 1 output register.
// Throughput: one pixel per cycle while the output is not stalled; three channel lanes run in parallel.
// The whole pipe holds while an output beat waits, so the input stalls with it.
// Reset (async, active low) clears valid bits and sets C=1.0, B=0, G=1.0.
module pixel_contrast_brightness_gamma_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_blue, out_green, out_red
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);
  import pcbg_pkg::*;

  logic [9:0] gain_q, offs_q, gamma_q;
  logic [9:0] gain, gamma;
  logic signed [9:0] offs;
  logic en;
  logic [23:0] lanes;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 10'd256;
      offs_q  <= 10'd0;
      gamma_q <= 10'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CONTRAST:   gain_q  <= cfg_data_i;
        REG_BRIGHTNESS: offs_q  <= cfg_data_i;
        REG_GAMMA:      gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // out-of-range settings fall back to defaults
  assign gain  = (gain_q > 10'd512) ? 10'd256 : gain_q;
  assign gamma = (gamma_q > 10'd512) ? 10'd256 : gamma_q;
  assign offs  = ($signed(offs_q) > 10'sd256 || $signed(offs_q) < -10'sd256) ?
                 10'sd0 : $signed(offs_q);

  assign s_axis_tready = en;

  for (genvar l = 0; l < LanesN; l++) begin : g_lane
    pcbg_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .pix_i   (s_axis_tdata[8*l +: 8]),
      .gain_i  (gain),
      .offs_i  (offs),
      .gamma_i (gamma),
      .pix_o   (lanes[8*l +: 8])
    );
  end

  pcbg_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .lane_i      (lanes),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .en_o        (en)
  );
endmodule

/* hw/rtl/pcbg_lane.sv */
module pcbg_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        pix_i,
  input  logic [9:0]        gain_i,
  input  logic signed [9:0] offs_i,
  input  logic [9:0]        gamma_i,
  output logic [7:0]        pix_o
);
  import pcbg_pkg::*;

  logic [DW-1:0] d_q;
  logic [9:0]    z_q;     // zero-channel flag per stage
  logic [4:0]    n_q [10];
  logic [15:0]   f_q [9];
  logic [VW-1:0] v_q [9];
  logic [VW-1:0] p_q;
  logic signed [41:0] s_q;
  logic z0_q;
  logic [20:0] e_d;
  logic [VW-1:0] p_d;
  logic signed [49:0] w;
  logic signed [11:0] q;

  assign e_d = 21'((30'(d_q) * 30'(gamma_i) + 30'd128) >> 8);

  always_comb begin
    if (z_q[9]) p_d = (gamma_i == '0) ? VW'(64'd1 << 30) : '0;
    else        p_d = v_q[8] >> n_q[9];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q    <= DTab[pix_i];
      z0_q   <= (pix_i == '0);
      n_q[0] <= e_d[20:16];
      f_q[0] <= e_d[15:0];
      z_q[0] <= z0_q;
      v_q[0] <= VTab[f_q[0][15:8]];
      n_q[1] <= n_q[0];
      f_q[1] <= f_q[0];
      z_q[1] <= z_q[0];
      p_q    <= p_d;
      s_q    <= $signed({1'b0, 41'(gain_i) * 41'(p_q)}) +
                ($signed(42'(offs_i)) <<< 30);
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_mul
    logic [2*VW-1:0] prod;
    assign prod = 62'(v_q[j]) * 62'(RTab[9 + j]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j+1] <= f_q[j+1][7-j] ? prod[60:30] : v_q[j];
        n_q[j+2] <= n_q[j+1];
        z_q[j+2] <= z_q[j+1];
        if (j < 7) begin
          f_q[j+2] <= f_q[j+1];
        end
      end
    end
  end

  // round and clamp: (255*s + 2^37) >> 38
  assign w = ($signed(50'(s_q)) <<< 8) - $signed(50'(s_q)) + $signed(50'd1 << 37);
  assign q = 12'(w >>> 38);
  assign pix_o = w[49] ? 8'd0 : (q > 12'sd255) ? 8'd255 : q[7:0];
endmodule

/* hw/rtl/pcbg_merge.sv */
module pcbg_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [23:0] lane_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [23:0] out_data_o,
  output logic        en_o
);
  import pcbg_pkg::*;

  logic [PipeN-1:0] vld_q;
  logic             ov_q;
  logic [23:0]      od_q;

  // advance the whole pipe unless the output beat is stuck
  assign en_o = out_ready_i | ~ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else if (en_o) begin
      vld_q <= {vld_q[PipeN-2:0], in_valid_i};
      ov_q  <= vld_q[PipeN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) od_q <= lane_i;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule
